// ===== rtl/lsfd_pkg.sv =====
// Shared types and constants for the LSB stego frame decoder.
`timescale 1ns / 1ps

package lsfd_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_HEADER_BYTES = 2'd0;
    localparam logic [1:0] REG_MAGIC_LEN    = 2'd1;
    localparam logic [1:0] REG_MAGIC_WORD   = 2'd2;
    localparam logic [1:0] REG_SUFFIX_LIMIT = 2'd3;

    // Register reset values
    localparam logic [7:0]  HEADER_BYTES_RST = 8'd54;
    localparam logic [3:0]  MAGIC_LEN_RST    = 4'd2;
    localparam logic [63:0] MAGIC_WORD_RST   = 64'd0;
    localparam logic [7:0]  SUFFIX_LIMIT_RST = 8'd5;

    // Longest magic string
    localparam logic [3:0] MAGIC_MAX = 4'd8;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_MAGIC,
        PH_LEN,
        PH_EXT,
        PH_SIZE,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [2:0] {
        KIND_EXT    = 3'd0,
        KIND_PAY    = 3'd1,
        KIND_MAGIC  = 3'd2,
        KIND_BADLEN = 3'd3,
        KIND_EMPTY  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0]  header_bytes;
        logic [3:0]  magic_len;
        logic [63:0] magic_word;
        logic [7:0]  suffix_limit;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

endpackage

// ===== rtl/lsfd_cfg_regs.sv =====
// Configuration register file of the LSB stego frame decoder.
`timescale 1ns / 1ps

module lsfd_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [63:0]       cfg_wdata,
    output lsfd_pkg::cfg_t    cfg
);

    lsfd_pkg::cfg_t cfg_reg;
    lsfd_pkg::cfg_t cfg_next;

    // Register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                lsfd_pkg::REG_HEADER_BYTES: cfg_next.header_bytes = cfg_wdata[7:0];
                lsfd_pkg::REG_MAGIC_LEN:    cfg_next.magic_len    = cfg_wdata[3:0];
                lsfd_pkg::REG_MAGIC_WORD:   cfg_next.magic_word   = cfg_wdata;
                lsfd_pkg::REG_SUFFIX_LIMIT: cfg_next.suffix_limit = cfg_wdata[7:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_bytes <= lsfd_pkg::HEADER_BYTES_RST;
            cfg_reg.magic_len    <= lsfd_pkg::MAGIC_LEN_RST;
            cfg_reg.magic_word   <= lsfd_pkg::MAGIC_WORD_RST;
            cfg_reg.suffix_limit <= lsfd_pkg::SUFFIX_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/lsfd_parser.sv =====
// Parse state and per-word decode of the hidden frame.
`timescale 1ns / 1ps

module lsfd_parser #(
    parameter int LEN_FIELD_BYTES  = 4,
    parameter int SIZE_FIELD_BYTES = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lsfd_pkg::cfg_t      cfg,
    input  logic                advance,
    input  logic [7:0]          image_byte,
    input  logic                start_req,
    output lsfd_pkg::result_t   res
);

    localparam int LEN_W  = 8 * LEN_FIELD_BYTES;
    localparam int SIZE_W = 8 * SIZE_FIELD_BYTES;
    localparam logic [7:0] LEN_LAST  = 8'(LEN_FIELD_BYTES - 1);
    localparam logic [7:0] SIZE_LAST = 8'(SIZE_FIELD_BYTES - 1);

    lsfd_pkg::phase_t   phase_reg, phase_next;
    logic [7:0]         hdr_cnt_reg, hdr_cnt_next;
    logic [2:0]         bit_cnt_reg, bit_cnt_next;
    logic [6:0]         shift_reg, shift_next;
    logic [7:0]         fld_cnt_reg, fld_cnt_next;
    logic               bad_reg, bad_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [SIZE_W-1:0]  size_reg, size_next;

    // working copies inside the decode block
    lsfd_pkg::phase_t   ph;
    logic [7:0]         fc;
    logic [7:0]         fc_inc;
    logic               take_bit;
    logic [7:0]         hb;
    logic [3:0]         mlen;
    logic [LEN_W-1:0]   len_shift;
    logic [SIZE_W-1:0]  size_shift;

    assign mlen = (cfg.magic_len > lsfd_pkg::MAGIC_MAX) ? lsfd_pkg::MAGIC_MAX
                                                         : cfg.magic_len;
    assign hb = {shift_reg, image_byte[0]};
    // little-endian fields: new byte enters at the top
    assign len_shift  = (len_reg >> 8) | (LEN_W'(hb) << (LEN_W - 8));
    assign size_shift = (size_reg >> 8) | (SIZE_W'(hb) << (SIZE_W - 8));

    // Next state and result for one word
    always_comb begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        fld_cnt_next = fld_cnt_reg;
        bad_next     = bad_reg;
        len_next     = len_reg;
        size_next    = size_reg;
        res          = '{valid: 1'b0, kind: lsfd_pkg::KIND_EXT, data: 8'd0, last: 1'b0};
        ph           = start_req ? lsfd_pkg::PH_HEADER : phase_reg;
        fc           = start_req ? 8'd0 : fld_cnt_reg;
        fc_inc       = 8'd0;
        take_bit     = 1'b0;

        if (advance && ph != lsfd_pkg::PH_IDLE) begin
            if (start_req) begin
                hdr_cnt_next = 8'd0;
                bit_cnt_next = 3'd0;
                bad_next     = 1'b0;
            end
            take_bit = 1'b1;
            if (ph == lsfd_pkg::PH_HEADER) begin
                if ((start_req ? 8'd0 : hdr_cnt_reg) < cfg.header_bytes) begin
                    hdr_cnt_next = (start_req ? 8'd0 : hdr_cnt_reg) + 8'd1;
                    take_bit     = 1'b0;
                end else begin
                    ph = lsfd_pkg::PH_MAGIC;
                    fc = 8'd0;
                end
            end

            if (take_bit) begin
                bit_cnt_next = (start_req ? 3'd0 : bit_cnt_reg) + 3'd1;
                shift_next   = hb[6:0];
                if ((start_req ? 3'd0 : bit_cnt_reg) == 3'd7) begin
                    // one hidden byte complete
                    if (ph == lsfd_pkg::PH_MAGIC && mlen == 4'd0) begin
                        ph = lsfd_pkg::PH_LEN;
                        fc = 8'd0;
                    end
                    fc_inc = fc + 8'd1;
                    case (ph)
                        lsfd_pkg::PH_MAGIC: begin
                            if (cfg.magic_word[8*fc[2:0] +: 8] != hb) begin
                                bad_next = 1'b1;
                            end
                            fc = fc_inc;
                            if (fc_inc >= {4'd0, mlen}) begin
                                fc = 8'd0;
                                if (bad_next) begin
                                    ph  = lsfd_pkg::PH_IDLE;
                                    res = '{valid: 1'b1, kind: lsfd_pkg::KIND_MAGIC,
                                            data: 8'd0, last: 1'b1};
                                end else begin
                                    ph = lsfd_pkg::PH_LEN;
                                end
                            end
                        end
                        lsfd_pkg::PH_LEN: begin
                            len_next = len_shift;
                            fc       = fc_inc;
                            if (fc == LEN_FIELD_BYTES[7:0] || fc_inc > LEN_LAST) begin
                                fc = 8'd0;
                                if (len_shift[LEN_W-1] || len_shift == '0 ||
                                    len_shift >= LEN_W'(cfg.suffix_limit)) begin
                                    ph  = lsfd_pkg::PH_IDLE;
                                    res = '{valid: 1'b1, kind: lsfd_pkg::KIND_BADLEN,
                                            data: 8'd0, last: 1'b1};
                                end else begin
                                    ph = lsfd_pkg::PH_EXT;
                                end
                            end
                        end
                        lsfd_pkg::PH_EXT: begin
                            // length is known to stay below 255
                            if (fc_inc >= len_reg[7:0]) begin
                                fc  = 8'd0;
                                ph  = lsfd_pkg::PH_SIZE;
                                res = '{valid: 1'b1, kind: lsfd_pkg::KIND_EXT,
                                        data: hb, last: 1'b1};
                            end else begin
                                fc  = fc_inc;
                                res = '{valid: 1'b1, kind: lsfd_pkg::KIND_EXT,
                                        data: hb, last: 1'b0};
                            end
                        end
                        lsfd_pkg::PH_SIZE: begin
                            size_next = size_shift;
                            fc        = fc_inc;
                            if (fc_inc > SIZE_LAST) begin
                                fc = 8'd0;
                                if (size_shift[SIZE_W-1] || size_shift == '0) begin
                                    ph  = lsfd_pkg::PH_IDLE;
                                    res = '{valid: 1'b1, kind: lsfd_pkg::KIND_EMPTY,
                                            data: 8'd0, last: 1'b1};
                                end else begin
                                    ph = lsfd_pkg::PH_PAYLOAD;
                                end
                            end
                        end
                        lsfd_pkg::PH_PAYLOAD: begin
                            // size register counts down the bytes still due
                            if (size_reg == SIZE_W'(1)) begin
                                ph  = lsfd_pkg::PH_IDLE;
                                res = '{valid: 1'b1, kind: lsfd_pkg::KIND_PAY,
                                        data: hb, last: 1'b1};
                            end else begin
                                size_next = size_reg - SIZE_W'(1);
                                res = '{valid: 1'b1, kind: lsfd_pkg::KIND_PAY,
                                        data: hb, last: 1'b0};
                            end
                        end
                        default: begin
                            ph = lsfd_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            phase_next   = ph;
            fld_cnt_next = fc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= lsfd_pkg::PH_HEADER;
            hdr_cnt_reg <= 8'd0;
            bit_cnt_reg <= 3'd0;
            fld_cnt_reg <= 8'd0;
            bad_reg     <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            bit_cnt_reg <= bit_cnt_next;
            fld_cnt_reg <= fld_cnt_next;
            bad_reg     <= bad_next;
        end
    end

    // assembly and count registers, fully overwritten before use
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        len_reg   <= len_next;
        size_reg  <= size_next;
    end

endmodule

// ===== rtl/lsb_stego_frame_decoder.sv =====
// Top level of the LSB stego frame decoder: stream ports, input and output stages.
`timescale 1ns / 1ps

// Decodes data hidden in the least significant bits of a stego image streamed one
// byte per word. Each word lands in an input register and, once the output slot
// is free, is decoded straight into the output register, so one word is taken
// every clock while the output side keeps up; a stalled output holds the input
// register, and the combined path from m_tready to s_tready is the only throttle.
// Setting tuser on a word restarts the parse at that word; after the single status
// or final byte the block ignores words until the next restart. Configuration
// writes are meant for idle periods only.
module lsb_stego_frame_decoder #(
    parameter int LEN_FIELD_BYTES  = 4,
    parameter int SIZE_FIELD_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] image_byte
    input  logic        s_tuser,   // [0] start_req
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);

    lsfd_pkg::cfg_t    cfg;
    lsfd_pkg::result_t res;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg;
    logic [2:0] m_kind_reg;
    logic       m_last_reg;
    logic       out_ready;
    logic       advance;

    lsfd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lsfd_parser #(
        .LEN_FIELD_BYTES  (LEN_FIELD_BYTES),
        .SIZE_FIELD_BYTES (SIZE_FIELD_BYTES)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .advance    (advance),
        .image_byte (in_byte_reg),
        .start_req  (in_start_reg),
        .res        (res)
    );

    // Handshake: the held word moves on when the output slot is free
    assign out_ready = !m_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_ready) begin
            m_valid_next = advance && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (advance && res.valid) begin
            m_data_reg <= res.data;
            m_kind_reg <= res.kind;
            m_last_reg <= res.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== test/lsb_stego_frame_decoder_test.sv =====
// Self-checking testbench for the LSB stego frame decoder: directed frames, a stall run, random ones.
`timescale 1ns / 1ps

module lsb_stego_frame_decoder_test;

    localparam int LEN_BYTES   = 4;
    localparam int SIZE_BYTES  = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 600000;
    localparam int N_ROWS      = 9;
    localparam int ITEM_TARGET = 800;

    // one decoded output word
    typedef struct {
        lsfd_pkg::kind_t kind;
        logic [7:0]      data;
        logic            fin;
    } decoded_t;

    // one directed frame: optional register set, then frame content
    typedef struct {
        bit              wr;
        logic [7:0]      hdr;
        logic [3:0]      mlen;
        logic [63:0]     mword;
        logic [7:0]      lim;
        bit              bad;
        logic [31:0]     elen;
        logic [63:0]     psize;
        int              cut;
        bit              fixed;
        lsfd_pkg::kind_t fkind;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [63:0] cfg_wdata;

    // decoder model state and register copy
    lsfd_pkg::cfg_t   cfg;
    lsfd_pkg::phase_t ph;
    logic [7:0]  hdr_cnt;
    logic [2:0]  bit_cnt;
    logic [7:0]  shreg;
    int          fld_cnt;
    logic        magic_bad;
    logic [31:0] ext_len;
    logic [63:0] pay_size;
    logic [63:0] pay_cnt;

    decoded_t    decoded_q[$];
    decoded_t    want;
    dir_row_t    dir_rows[N_ROWS];

    bit              row_fixed;
    lsfd_pkg::kind_t fixed_kind;
    bit          idle_on;
    bit          hold_req;
    int          hold_cnt;
    int          errors;
    int          checked;
    int          result_cnt;
    int          busy_words;
    int          sent_words;
    int          frame_cnt;
    int          cycle_cnt;

    lsb_stego_frame_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d results still owed", cycle_cnt, decoded_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void clear_parse();
        ph        = lsfd_pkg::PH_HEADER;
        hdr_cnt   = '0;
        bit_cnt   = '0;
        shreg     = '0;
        fld_cnt   = 0;
        magic_bad = 1'b0;
        ext_len   = '0;
        pay_size  = '0;
        pay_cnt   = '0;
    endfunction

    // queue one result; directed status rows carry their own typed value
    function automatic void owe(input lsfd_pkg::kind_t k, input logic [7:0] d, input logic f);
        decoded_t r;
        r.kind = k;
        r.data = d;
        r.fin  = f;
        if (row_fixed && k >= lsfd_pkg::KIND_MAGIC) begin
            r.kind = fixed_kind;
            r.data = 8'h00;
            r.fin  = 1'b1;
        end
        decoded_q.push_back(r);
        result_cnt++;
    endfunction

    // advance the decoder model by one accepted image word
    function automatic void decode_word(input logic [7:0] b, input logic st);
        logic [7:0] hb;
        int         mlen;
        if (st)
            clear_parse();
        if (ph == lsfd_pkg::PH_IDLE)
            return;
        busy_words++;
        if (ph == lsfd_pkg::PH_HEADER) begin
            if (hdr_cnt < cfg.header_bytes) begin
                hdr_cnt++;
                return;
            end
            ph      = lsfd_pkg::PH_MAGIC;
            fld_cnt = 0;
        end
        shreg   = {shreg[6:0], b[0]};
        bit_cnt = bit_cnt + 3'd1;
        if (bit_cnt != 3'd0)
            return;
        hb    = shreg;
        shreg = '0;
        mlen  = (cfg.magic_len > lsfd_pkg::MAGIC_MAX) ? 8 : int'(cfg.magic_len);
        if (ph == lsfd_pkg::PH_MAGIC && mlen == 0) begin
            ph      = lsfd_pkg::PH_LEN;
            fld_cnt = 0;
        end
        case (ph)
            lsfd_pkg::PH_MAGIC: begin
                if (cfg.magic_word[8*fld_cnt +: 8] != hb)
                    magic_bad = 1'b1;
                fld_cnt++;
                if (fld_cnt >= mlen) begin
                    fld_cnt = 0;
                    if (magic_bad) begin
                        ph = lsfd_pkg::PH_IDLE;
                        owe(lsfd_pkg::KIND_MAGIC, 8'h00, 1'b1);
                    end else begin
                        ph = lsfd_pkg::PH_LEN;
                    end
                end
            end
            lsfd_pkg::PH_LEN: begin
                ext_len[8*fld_cnt +: 8] = hb;
                fld_cnt++;
                if (fld_cnt >= LEN_BYTES) begin
                    fld_cnt = 0;
                    if (ext_len[31] || ext_len == 0 || ext_len >= cfg.suffix_limit) begin
                        ph = lsfd_pkg::PH_IDLE;
                        owe(lsfd_pkg::KIND_BADLEN, 8'h00, 1'b1);
                    end else begin
                        ph = lsfd_pkg::PH_EXT;
                    end
                end
            end
            lsfd_pkg::PH_EXT: begin
                fld_cnt++;
                if (fld_cnt >= ext_len) begin
                    fld_cnt = 0;
                    ph      = lsfd_pkg::PH_SIZE;
                    owe(lsfd_pkg::KIND_EXT, hb, 1'b1);
                end else begin
                    owe(lsfd_pkg::KIND_EXT, hb, 1'b0);
                end
            end
            lsfd_pkg::PH_SIZE: begin
                pay_size[8*fld_cnt +: 8] = hb;
                fld_cnt++;
                if (fld_cnt >= SIZE_BYTES) begin
                    fld_cnt = 0;
                    if (pay_size[63] || pay_size == 0) begin
                        ph = lsfd_pkg::PH_IDLE;
                        owe(lsfd_pkg::KIND_EMPTY, 8'h00, 1'b1);
                    end else begin
                        pay_cnt = '0;
                        ph      = lsfd_pkg::PH_PAYLOAD;
                    end
                end
            end
            lsfd_pkg::PH_PAYLOAD: begin
                pay_cnt++;
                if (pay_cnt >= pay_size) begin
                    ph = lsfd_pkg::PH_IDLE;
                    owe(lsfd_pkg::KIND_PAY, hb, 1'b1);
                end else begin
                    owe(lsfd_pkg::KIND_PAY, hb, 1'b0);
                end
            end
            default: ;
        endcase
    endfunction

    // offer one word, with random gaps, until it is taken
    task automatic send_word(input logic [7:0] b, input logic st);
        @(negedge aclk);
        while (idle_on && $urandom_range(0, 99) < 36) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = st;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent_words++;
        decode_word(b, st);
    endtask

    // stop sending and wait until every owed result is out
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (decoded_q.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        case (idx)
            lsfd_pkg::REG_HEADER_BYTES: cfg.header_bytes = val[7:0];
            lsfd_pkg::REG_MAGIC_LEN:    cfg.magic_len    = val[3:0];
            lsfd_pkg::REG_MAGIC_WORD:   cfg.magic_word   = val;
            lsfd_pkg::REG_SUFFIX_LIMIT: cfg.suffix_limit = val[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_cfg(input logic [7:0] h, input logic [3:0] m,
                             input logic [63:0] w, input logic [7:0] l);
        set_reg(lsfd_pkg::REG_HEADER_BYTES, 64'(h));
        set_reg(lsfd_pkg::REG_MAGIC_LEN, 64'(m));
        set_reg(lsfd_pkg::REG_MAGIC_WORD, w);
        set_reg(lsfd_pkg::REG_SUFFIX_LIMIT, 64'(l));
    endtask

    // build one image and stream it; stops early once the parse has ended or at cut
    task automatic run_frame(input bit bad, input logic [31:0] elen, input logic [63:0] psize,
                             input int cut, input int noise);
        logic [7:0] hq[$];
        logic [7:0] img[$];
        logic [7:0] ch;
        int         mlen;
        int         n;
        int         k;
        int         i;
        int         pick;
        mlen = (cfg.magic_len > lsfd_pkg::MAGIC_MAX) ? 8 : int'(cfg.magic_len);
        pick = (mlen > 0) ? $urandom_range(0, mlen - 1) : 0;
        for (k = 0; k < mlen; k++) begin
            ch = cfg.magic_word[8*k +: 8];
            if (bad && k == pick)
                ch ^= 8'($urandom_range(1, 255));
            hq.push_back(ch);
        end
        for (k = 0; k < LEN_BYTES; k++)
            hq.push_back(elen[8*k +: 8]);
        n = (elen < 256) ? int'(elen) : 0;
        repeat (n) hq.push_back(8'($urandom));
        for (k = 0; k < SIZE_BYTES; k++)
            hq.push_back(psize[8*k +: 8]);
        n = psize[63] ? 0 : ((psize > 300) ? 300 : int'(psize));
        repeat (n) hq.push_back(8'($urandom));
        // header, then each hidden byte spread over eight LSBs, MSB first
        repeat (cfg.header_bytes) img.push_back(8'($urandom));
        foreach (hq[j])
            for (i = 7; i >= 0; i--)
                img.push_back({7'($urandom), hq[j][i]});
        frame_cnt++;
        for (k = 0; k < img.size(); k++) begin
            if (cut != 0 && k >= cut)
                break;
            if (k > 0 && ph == lsfd_pkg::PH_IDLE)
                break;
            send_word(img[k], k == 0);
        end
        repeat (noise) send_word(8'($urandom), 1'b0);
    endtask

    // receiver: random back-pressure, plus one long hold on request
    initial begin
        m_tready = 1'b0;
        hold_cnt = 0;
        forever begin
            @(negedge aclk);
            if (hold_cnt != 0) begin
                m_tready = 1'b0;
                hold_cnt--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
                m_tready = 1'b0;
            end else begin
                m_tready = !(idle_on && $urandom_range(0, 99) < 36);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected word: kind %0d byte %02h last %0b",
                             m_tuser, m_tdata, m_tlast);
            end else begin
                want = decoded_q.pop_front();
                checked++;
                if (m_tuser !== want.kind || m_tdata !== want.data || m_tlast !== want.fin) begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch on word %0d: want kind %0d byte %02h last %0b, %s",
                                 checked, want.kind, want.data, want.fin,
                                 $sformatf("got kind %0d byte %02h last %0b",
                                           m_tuser, m_tdata, m_tlast));
                end
            end
        end
    end

    initial begin
        int          r;
        int          ilim;
        bit          bad;
        logic [31:0] elen;
        logic [63:0] psize;
        logic [7:0]  h;
        logic [3:0]  m;
        logic [7:0]  l;

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = lsfd_pkg::REG_HEADER_BYTES;
        cfg_wdata  = '0;
        hold_req   = 1'b0;
        idle_on    = 1'b1;
        row_fixed  = 1'b0;
        fixed_kind = lsfd_pkg::KIND_EXT;
        errors     = 0;
        checked    = 0;
        result_cnt = 0;
        busy_words = 0;
        sent_words = 0;
        frame_cnt  = 0;
        cfg.header_bytes = lsfd_pkg::HEADER_BYTES_RST;
        cfg.magic_len    = lsfd_pkg::MAGIC_LEN_RST;
        cfg.magic_word   = lsfd_pkg::MAGIC_WORD_RST;
        cfg.suffix_limit = lsfd_pkg::SUFFIX_LIMIT_RST;
        clear_parse();

        // wr  hdr     mlen   magic word              limit  bad  ext len  size  cut  fixed
        // reset registers, zero extension length
        dir_rows[0] = '{1'b0, 8'd54, 4'd2, 64'd0, 8'd5, 1'b0, 32'd0, 64'd1, 0, 1'b1,
                        lsfd_pkg::KIND_BADLEN};
        dir_rows[1] = '{1'b1, 8'd0, 4'd1, 64'h41, 8'd5, 1'b1, 32'd1, 64'd1, 0, 1'b1,
                        lsfd_pkg::KIND_MAGIC};
        // magic check skipped, extension length equal to the limit
        dir_rows[2] = '{1'b1, 8'd0, 4'd0, 64'h0, 8'd5, 1'b0, 32'd5, 64'd1, 0, 1'b1,
                        lsfd_pkg::KIND_BADLEN};
        dir_rows[3] = '{1'b0, 8'd0, 4'd0, 64'h0, 8'd5, 1'b0, 32'h8000_0002, 64'd1, 0,
                        1'b1, lsfd_pkg::KIND_BADLEN};
        dir_rows[4] = '{1'b0, 8'd0, 4'd0, 64'h0, 8'd5, 1'b0, 32'd1, 64'd0, 0, 1'b1,
                        lsfd_pkg::KIND_EMPTY};
        // magic length above eight, all-ones magic
        dir_rows[5] = '{1'b1, 8'd0, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 1'b0, 32'd0,
                        64'd1, 0, 1'b1, lsfd_pkg::KIND_BADLEN};
        // longest extension, cut after two of its bytes
        dir_rows[6] = '{1'b1, 8'd0, 4'd0, 64'h0, 8'd255, 1'b0, 32'd254, 64'd2, 48, 1'b0,
                        lsfd_pkg::KIND_EXT};
        // huge payload cut off mid hidden byte, then restart mid-payload
        dir_rows[7] = '{1'b1, 8'd1, 4'd0, 64'h0, 8'd8, 1'b0, 32'd1,
                        64'h0000_0100_0000_0000, 116, 1'b0, lsfd_pkg::KIND_EXT};
        dir_rows[8] = '{1'b0, 8'd0, 4'd0, 64'd0, 8'd0, 1'b0, 32'd0, 64'd1, 0, 1'b1,
                        lsfd_pkg::KIND_BADLEN};

        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // directed frames
        for (r = 0; r < N_ROWS; r++) begin
            if (dir_rows[r].wr) begin
                drain();
                apply_cfg(dir_rows[r].hdr, dir_rows[r].mlen, dir_rows[r].mword,
                          dir_rows[r].lim);
            end
            row_fixed  = dir_rows[r].fixed;
            fixed_kind = dir_rows[r].fkind;
            run_frame(dir_rows[r].bad, dir_rows[r].elen, dir_rows[r].psize, dir_rows[r].cut, 1);
            row_fixed = 1'b0;
        end

        // full rate on both sides with a long output hold: input must back up
        drain();
        apply_cfg(8'd0, 4'd1, 64'h77, 8'd10);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        run_frame(1'b1, 32'd1, 64'd1, 0, 20);
        drain();
        idle_on = 1'b1;

        // random frames with random registers between them
        while (sent_words < ITEM_TARGET) begin
            if (ph == lsfd_pkg::PH_IDLE && $urandom_range(0, 3) == 0) begin
                drain();
                r = $urandom_range(0, 19);
                h = (r == 0) ? 8'd255 : (r == 1) ? 8'd0 : 8'($urandom_range(1, 10));
                m = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(1, 3));
                r = $urandom_range(0, 9);
                l = (r == 0) ? 8'($urandom_range(0, 1)) : (r == 1) ? 8'd255
                                                        : 8'($urandom_range(2, 12));
                apply_cfg(h, m, {$urandom, $urandom}, l);
            end
            if ($urandom_range(0, 9) == 0) begin
                // loose words, rare restarts
                repeat ($urandom_range(1, 12))
                    send_word(8'($urandom), $urandom_range(0, 15) == 0);
            end else begin
                bad  = ($urandom_range(0, 9) == 0);
                ilim = int'(cfg.suffix_limit);
                if (ilim > 1 && $urandom_range(0, 9) < 8) begin
                    elen = $urandom_range(1, (ilim > 9) ? 8 : ilim - 1);
                end else begin
                    case ($urandom_range(0, 2))
                        0:       elen = 32'd0;
                        1:       elen = 32'(ilim);
                        default: elen = $urandom;
                    endcase
                end
                if ($urandom_range(0, 9) < 8) begin
                    psize = 64'($urandom_range(1, 6));
                end else begin
                    case ($urandom_range(0, 2))
                        0:       psize = 64'd0;
                        1:       psize = {1'b1, 31'($urandom), $urandom};
                        default: psize = {32'd1, $urandom};
                    endcase
                end
                run_frame(bad, elen, psize,
                          ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200) : 0,
                          $urandom_range(0, 4));
            end
            if ($urandom_range(0, 7) == 0)
                drain();
        end

        drain();
        repeat (20) @(posedge aclk);
        if (decoded_q.size() != 0) begin
            errors++;
            $display("%0d results never arrived", decoded_q.size());
        end
        $display("Ran %0d frames, %0d image words sent, %0d parsed, %0d output words checked",
                 frame_cnt, sent_words, busy_words, checked);
        $display("Header skip, magic, length, extension, size, payload, restarts and stalls hit");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d failures", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
